FILE: rtl/core/tccw_pkg.sv
// Shared types, codes and constants of the text console character writer.
package tccw_pkg;

  // Default screen geometry
  localparam int unsigned COLUMNS_DEF  = 80;
  localparam int unsigned ROWS_DEF     = 25;
  localparam int unsigned TAB_STOP_DEF = 8;

  // Fixed field widths
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned ATTR_W    = 2 * COLOR_W;
  localparam int unsigned CELL_W    = CHAR_W + ATTR_W;
  localparam int unsigned COL_OUT_W = 7;
  localparam int unsigned ROW_OUT_W = 5;
  localparam int unsigned OFF_OUT_W = 11;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'h7F;

  // Reset contents and colours
  localparam logic [CELL_W-1:0]  BLANK_RESET = 16'h0F20;
  localparam logic [COLOR_W-1:0] FORE_RESET  = 4'hF;
  localparam logic [COLOR_W-1:0] BACK_RESET  = 4'h0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new request
    logic exec;        // carry out the request
    logic sweep_en;    // write one blank cell and advance the sweep
    logic sweep_full;  // sweep the whole screen rather than one row
    logic sweep_init;  // use the power-on blank instead of the current one
    logic finish;      // load the result registers and strobe
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             scroll;
    logic             sweep_last;
  } dp_status_t;

endpackage

FILE: rtl/core/tccw_ctrl.sv
// Controller state machine of the text console character writer.
module tccw_ctrl import tccw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_en   = 1'b1;
        cmd_o.sweep_full = 1'b1;
        cmd_o.sweep_init = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        unique case (status_i.req)
          REQ_PUT:   state_d = status_i.scroll ? ST_SCROLL : ST_FINISH;
          REQ_CLEAR: state_d = ST_CLEAR;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_SCROLL: begin
        cmd_o.sweep_en = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep_en   = 1'b1;
        cmd_o.sweep_full = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tccw_datapath.sv
// Datapath of the text console character writer: cursor, cell store, sweeps.
module tccw_datapath import tccw_pkg::*; #(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  input  logic [ATTR_W-1:0]    attr_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [ROW_OUT_W-1:0] cell_row_i,
  input  logic [COL_OUT_W-1:0] cell_col_i,
  output logic                 done_o,
  output logic [COL_OUT_W-1:0] cursor_col_o,
  output logic [ROW_OUT_W-1:0] cursor_row_o,
  output logic [OFF_OUT_W-1:0] cursor_offset_o,
  output logic [CELL_W-1:0]    cell_data_o
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned PH_W  = $clog2(TAB_STOP);
  localparam int unsigned NCW   = $clog2(COLUMNS + TAB_STOP);
  localparam int unsigned OFFW  = ROW_W + COL_W + 1;
  localparam int unsigned AW    = ROW_W + COL_W;
  localparam int unsigned DEPTH = ROWS * (1 << COL_W);

  // Captured request
  logic [REQ_W-1:0]  req_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;
  logic              rd_ok_q;

  // Cursor, tab phase (column modulo tab stop) and top row of the ring
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [PH_W-1:0]  phase_q;
  logic [ROW_W-1:0] top_q;

  logic [COL_W-1:0] sweep_col_q;
  logic [ROW_W-1:0] sweep_row_q;

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rd_q;

  // Next cursor for a put
  logic [NCW-1:0]   nc;
  logic [ROW_W:0]   nr;
  logic [PH_W-1:0]  np;
  logic             printable;
  logic             scroll;

  always_comb begin
    nc        = NCW'(col_q);
    nr        = (ROW_W+1)'(row_q);
    np        = phase_q;
    printable = (char_q >= CHAR_SPACE) && (char_q <= CHAR_DEL);
    if (char_q == CHAR_BS) begin
      if (col_q != '0) begin
        nc = NCW'(col_q) - NCW'(1);
        np = (phase_q == '0) ? PH_W'(TAB_STOP - 1) : phase_q - PH_W'(1);
      end
    end else if (char_q == CHAR_TAB) begin
      nc = NCW'(col_q) + NCW'(TAB_STOP) - NCW'(phase_q);
      np = '0;
    end else if (char_q == CHAR_CR) begin
      nc = '0;
      np = '0;
    end else if (char_q == CHAR_LF) begin
      nc = '0;
      np = '0;
      nr = (ROW_W+1)'(row_q) + (ROW_W+1)'(1);
    end else if (printable) begin
      nc = NCW'(col_q) + NCW'(1);
      np = (phase_q == PH_W'(TAB_STOP - 1)) ? '0 : phase_q + PH_W'(1);
    end
    // wrap at the right edge
    if (nc >= NCW'(COLUMNS)) begin
      nc = '0;
      np = '0;
      nr = nr + (ROW_W+1)'(1);
    end
    scroll = (nr == (ROW_W+1)'(ROWS));
    if (scroll) begin
      nr = (ROW_W+1)'(ROWS - 1);
    end
  end

  // Logical to physical row through the ring offset
  logic [ROW_W-1:0] lrow;
  logic [ROW_W:0]   psum;
  logic [ROW_W-1:0] prow;

  always_comb begin
    lrow = (req_q == REQ_READ) ? rrow_q : row_q;
    psum = (ROW_W+1)'(lrow) + (ROW_W+1)'(top_q);
    if (psum >= (ROW_W+1)'(ROWS)) begin
      psum = psum - (ROW_W+1)'(ROWS);
    end
    prow = psum[ROW_W-1:0];
  end

  // Memory port select
  logic              sweep_last;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata;

  assign sweep_last = (sweep_col_q == COL_W'(COLUMNS - 1)) &&
                      (!cmd_i.sweep_full || (sweep_row_q == ROW_W'(ROWS - 1)));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {prow, (req_q == REQ_READ) ? rcol_q : col_q};
    mem_wdata = {attr_i, char_q};
    if (cmd_i.sweep_en) begin
      mem_we    = 1'b1;
      mem_addr  = {cmd_i.sweep_full ? sweep_row_q : top_q, sweep_col_q};
      mem_wdata = cmd_i.sweep_init ? BLANK_RESET : {attr_i, CHAR_SPACE};
    end else if (cmd_i.exec && (req_q == REQ_PUT) && printable) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      char_q  <= char_code_i;
      rrow_q  <= ROW_W'(cell_row_i);
      rcol_q  <= COL_W'(cell_col_i);
      rd_ok_q <= (int'(cell_row_i) < int'(ROWS)) && (int'(cell_col_i) < int'(COLUMNS));
    end
  end

  // Cursor, ring offset and sweep counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      top_q       <= '0;
      sweep_col_q <= '0;
      sweep_row_q <= '0;
    end else begin
      if (cmd_i.exec) begin
        if (req_q == REQ_PUT) begin
          col_q   <= nc[COL_W-1:0];
          row_q   <= nr[ROW_W-1:0];
          phase_q <= np;
        end else if (req_q == REQ_CLEAR) begin
          col_q   <= '0;
          row_q   <= '0;
          phase_q <= '0;
          top_q   <= '0;
        end
      end
      if (cmd_i.sweep_en) begin
        if (sweep_col_q == COL_W'(COLUMNS - 1)) begin
          sweep_col_q <= '0;
          if (cmd_i.sweep_full) begin
            sweep_row_q <= (sweep_row_q == ROW_W'(ROWS - 1)) ? '0 : sweep_row_q + ROW_W'(1);
          end else begin
            // the blanked old top row becomes the bottom row
            top_q <= (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
          end
        end else begin
          sweep_col_q <= sweep_col_q + COL_W'(1);
        end
      end
    end
  end

  // Result registers
  logic [OFFW-1:0] offset;

  assign offset = OFFW'(row_q) * OFFW'(COLUMNS) + OFFW'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      cursor_col_o    <= COL_OUT_W'(col_q);
      cursor_row_o    <= ROW_OUT_W'(row_q);
      cursor_offset_o <= offset[OFF_OUT_W-1:0];
      cell_data_o     <= ((req_q == REQ_READ) && rd_ok_q) ? rd_q : '0;
    end
  end

  assign status_o.req        = req_q;
  assign status_o.scroll     = scroll;
  assign status_o.sweep_last = sweep_last;

endmodule

FILE: rtl/core/text_console_char_writer.sv
// Top level of the text console character writer: colour registers, controller, datapath.
//
// A ROWS x COLUMNS text console (80x25 by default) of 16-bit cells, attribute high and
// character low, with a cursor. A request is taken at a rising edge with start high and
// busy low; its single result appears on the result ports for exactly one cycle with
// done_o high and cannot be held off, so capture it then. A put, a read or an unused
// request code passes from transfer to strobe through the capture, execute and result
// steps of the controller. Scrolling is done by moving the top-row pointer of a ring of
// rows and blanking one row through the single cell-store port, so a put that scrolls
// adds a step that blanks that row cell by cell. A clear sweeps every cell through that
// port. After reset the block runs a clearing pass with busy high before it takes its
// first request. Colour registers are written on a channel of their own, always ready;
// write them only while the block is idle.
module text_console_char_writer import tccw_pkg::*; #(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [ROW_OUT_W-1:0] cell_row_i,
  input  logic [COL_OUT_W-1:0] cell_col_i,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i,
  // result
  output logic                 done_o,
  output logic [COL_OUT_W-1:0] cursor_col_o,
  output logic [ROW_OUT_W-1:0] cursor_row_o,
  output logic [OFF_OUT_W-1:0] cursor_offset_o,
  output logic [CELL_W-1:0]    cell_data_o
);

  // Colour registers; the attribute byte is background high, foreground low
  logic [COLOR_W-1:0] fore_q, fore_d;
  logic [COLOR_W-1:0] back_q, back_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    fore_d = fore_q;
    back_d = back_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FORE_COLOR: fore_d = cfg_wdata_i;
        CFG_BACK_COLOR: back_d = cfg_wdata_i;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= FORE_RESET;
      back_q <= BACK_RESET;
    end else begin
      fore_q <= fore_d;
      back_q <= back_d;
    end
  end

  dp_cmd_t    cmd;
  dp_status_t status;

  tccw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tccw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .attr_i          ({back_q, fore_q}),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .cell_row_i      (cell_row_i),
    .cell_col_i      (cell_col_i),
    .done_o          (done_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_offset_o (cursor_offset_o),
    .cell_data_o     (cell_data_o)
  );

  // The strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A transfer always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request taken without going busy");

  // A result follows work in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(busy))
    else $error("result strobe without a request in progress");

  // The reported column stays on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> (int'(cursor_col_o) < int'(COLUMNS)))
    else $error("cursor column off the screen");

endmodule

FILE: tb/text_console_char_writer_checker.sv
`timescale 1ns / 1ps
// Result predictor and comparator for the text console character writer.
module text_console_char_writer_checker import tccw_pkg::*; #(
  parameter int unsigned COLUMNS  = COLUMNS_DEF,
  parameter int unsigned ROWS     = ROWS_DEF,
  parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [ROW_OUT_W-1:0] cell_row_i,
  input  logic [COL_OUT_W-1:0] cell_col_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i,
  input  logic                 done_i,
  input  logic [COL_OUT_W-1:0] cursor_col_i,
  input  logic [ROW_OUT_W-1:0] cursor_row_i,
  input  logic [OFF_OUT_W-1:0] cursor_offset_i,
  input  logic [CELL_W-1:0]    cell_data_i,
  input  logic                 drain_done_i,
  output int unsigned          pending_o,
  output int unsigned          error_count_o
);

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic [OFF_OUT_W-1:0] offset;
    logic [CELL_W-1:0]    data;
  } cursor_report_t;

  logic [CELL_W-1:0]  screen_model [ROWS*COLUMNS];
  int unsigned        col_model;
  int unsigned        row_model;
  logic [COLOR_W-1:0] fore_model;
  logic [COLOR_W-1:0] back_model;
  cursor_report_t     awaited_reports [$];
  bit                 leftovers_reported;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {back_model, fore_model, CHAR_SPACE};
  endfunction

  task automatic report(input string msg);
    error_count_o++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    int unsigned i;
    if (ch == CHAR_BS) begin
      if (col_model != 0) col_model--;
    end else if (ch == CHAR_TAB) begin
      col_model = (col_model / TAB_STOP + 1) * TAB_STOP;
    end else if (ch == CHAR_CR) begin
      col_model = 0;
    end else if (ch == CHAR_LF) begin
      col_model = 0;
      row_model++;
    end else if (ch >= CHAR_SPACE && ch <= CHAR_DEL) begin
      screen_model[row_model*COLUMNS + col_model] = {back_model, fore_model, ch};
      col_model++;
    end
    if (col_model >= COLUMNS) begin
      col_model = 0;
      row_model++;
    end
    // scroll: move every row up one, blank the bottom row
    if (row_model >= ROWS) begin
      for (i = 0; i < (ROWS-1)*COLUMNS; i++) screen_model[i] = screen_model[i+COLUMNS];
      for (i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++) screen_model[i] = blank_cell();
      row_model = ROWS - 1;
    end
  endtask

  task automatic predict_request();
    cursor_report_t r;
    int unsigned    i;
    r.data = '0;
    case (req_type_i)
      REQ_PUT: put_char(char_code_i);
      REQ_READ: begin
        if (cell_row_i < ROWS && cell_col_i < COLUMNS)
          r.data = screen_model[cell_row_i*COLUMNS + cell_col_i];
      end
      REQ_CLEAR: begin
        for (i = 0; i < ROWS*COLUMNS; i++) screen_model[i] = blank_cell();
        col_model = 0;
        row_model = 0;
      end
      default: ;
    endcase
    r.col    = COL_OUT_W'(col_model);
    r.row    = ROW_OUT_W'(row_model);
    r.offset = OFF_OUT_W'(row_model*COLUMNS + col_model);
    awaited_reports.push_back(r);
  endtask

  task automatic check_result();
    cursor_report_t r;
    if (awaited_reports.size() == 0) begin
      report($sformatf("result with none awaited (col %0d row %0d cell 0x%04h)",
                       cursor_col_i, cursor_row_i, cell_data_i));
      return;
    end
    r = awaited_reports.pop_front();
    if (cursor_col_i !== r.col)
      report($sformatf("cursor column: got %0d, expected %0d", cursor_col_i, r.col));
    if (cursor_row_i !== r.row)
      report($sformatf("cursor row: got %0d, expected %0d", cursor_row_i, r.row));
    if (cursor_offset_i !== r.offset)
      report($sformatf("cursor offset: got %0d, expected %0d", cursor_offset_i, r.offset));
    if (cell_data_i !== r.data)
      report($sformatf("cell data: got 0x%04h, expected 0x%04h", cell_data_i, r.data));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < ROWS*COLUMNS; i++) screen_model[i] = BLANK_RESET;
      col_model          = 0;
      row_model          = 0;
      fore_model         = FORE_RESET;
      back_model         = BACK_RESET;
      leftovers_reported = 1'b0;
      error_count_o      = 0;
      awaited_reports.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FORE_COLOR: fore_model = cfg_wdata_i;
          CFG_BACK_COLOR: back_model = cfg_wdata_i;
          default: ;
        endcase
      end
      if (done_i) check_result();
      if (start_i && !busy_i) predict_request();
      if (drain_done_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        if (awaited_reports.size() != 0)
          report($sformatf("%0d results never arrived", awaited_reports.size()));
      end
      pending_o <= awaited_reports.size();
    end
  end

endmodule

FILE: tb/text_console_char_writer_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the text console character writer, with the checker beside it.
module text_console_char_writer_test;
  import tccw_pkg::*;

  // Geometry of the default build, used for directed reads and in-range picks
  localparam int unsigned COLS = COLUMNS_DEF;
  localparam int unsigned ROWS = ROWS_DEF;

  // Codes the package leaves unnamed: the spare request code and a spare register
  localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  // Run shape. The limit allows every item to be a full clear plus the longest
  // sender gap, on top of the clearing pass after reset, several times over.
  localparam int unsigned ITEMS_PER_PHASE = 135;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 5_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     req_type;
  logic [CHAR_W-1:0]    char_code;
  logic [ROW_OUT_W-1:0] cell_row;
  logic [COL_OUT_W-1:0] cell_col;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;
  logic                 done;
  logic [COL_OUT_W-1:0] cursor_col;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [OFF_OUT_W-1:0] cursor_offset;
  logic [CELL_W-1:0]    cell_data;
  logic                 drain_done;
  int unsigned          pending;
  int unsigned          error_count;

  // Stimulus bookkeeping
  bit          holding;      // start is being held high for back-to-back transfers
  int unsigned idle_pct;     // chance, in percent, of a sender gap after a transfer
  int unsigned n_put, n_read, n_clear, n_unused, n_cfg;
  int unsigned cycle_count;

  always #5 clk_i = ~clk_i;

  text_console_char_writer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type),
    .char_code_i     (char_code),
    .cell_row_i      (cell_row),
    .cell_col_i      (cell_col),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .done_o          (done),
    .cursor_col_o    (cursor_col),
    .cursor_row_o    (cursor_row),
    .cursor_offset_o (cursor_offset),
    .cell_data_o     (cell_data)
  );

  text_console_char_writer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_type_i      (req_type),
    .char_code_i     (char_code),
    .cell_row_i      (cell_row),
    .cell_col_i      (cell_col),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .done_i          (done),
    .cursor_col_i    (cursor_col),
    .cursor_row_i    (cursor_row),
    .cursor_offset_i (cursor_offset),
    .cell_data_i     (cell_data),
    .drain_done_i    (drain_done),
    .pending_o       (pending),
    .error_count_o   (error_count)
  );

  // Watchdog: abandon the run if it overstays the limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run abandoned after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("text_console_char_writer: mismatch");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. Start stays high
  // afterwards unless a sender gap is drawn, so the next call can follow on
  // back to back without lowering and raising start in the same step.
  task automatic send_request(input logic [REQ_W-1:0]     req,
                              input logic [CHAR_W-1:0]    ch,
                              input logic [ROW_OUT_W-1:0] row,
                              input logic [COL_OUT_W-1:0] col);
    req_type  <= req;
    char_code <= ch;
    cell_row  <= row;
    cell_col  <= col;
    start     <= 1'b1;
    holding   = 1'b1;
    // the transfer happens at the first edge that sees busy low
    do @(posedge clk_i); while (busy);
    case (req)
      REQ_PUT:   n_put++;
      REQ_READ:  n_read++;
      REQ_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
    if ($urandom_range(0, 99) < idle_pct) begin
      start   <= 1'b0;
      holding = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Put a byte, with random content on the fields a put ignores
  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_request(REQ_PUT, ch, ROW_OUT_W'($urandom_range(0, 31)),
                 COL_OUT_W'($urandom_range(0, 127)));
  endtask

  // Read a cell: mostly on screen, sometimes anywhere the field widths reach
  task automatic send_read();
    if ($urandom_range(0, 99) < 75)
      send_request(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                   ROW_OUT_W'($urandom_range(0, ROWS-1)),
                   COL_OUT_W'($urandom_range(0, COLS-1)));
    else
      send_request(REQ_READ, CHAR_W'($urandom_range(0, 255)),
                   ROW_OUT_W'($urandom_range(0, 31)),
                   COL_OUT_W'($urandom_range(0, 127)));
  endtask

  // Drop start and hold off until every result is in and the block is idle.
  // The first edge lets the checker register a transfer made at this very step.
  task automatic drain();
    if (holding) begin
      start   <= 1'b0;
      holding = 1'b0;
    end
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
  endtask

  // One transfer on the register channel; cfg_valid is left high for the caller
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk_i); while (!cfg_ready);
    n_cfg++;
  endtask

  // Set both colours back to back, optionally poking the spare index as well
  task automatic set_colours(input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back,
                             input bit poke_spare);
    cfg_write(CFG_FORE_COLOR, fore);
    if (poke_spare) cfg_write(CFG_SPARE, COLOR_W'($urandom_range(0, 15)));
    cfg_write(CFG_BACK_COLOR, back);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic built from short sequences: lines of text with the odd
  // control byte, runs of line feeds that push the cursor to the bottom and scroll,
  // bursts of reads, spare request codes, the occasional clear and raw noise bytes.
  task automatic run_random(input int unsigned quota);
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    int unsigned sel;
    first = n_put + n_read + n_clear + n_unused;
    while (n_put + n_read + n_clear + n_unused - first < quota) begin
      pick = $urandom_range(0, 99);
      // now and then hold off until the block has fully drained
      if ($urandom_range(0, 99) < 3) drain();
      if (pick < 45) begin
        len = $urandom_range(1, 100);
        repeat (len) begin
          sel = $urandom_range(0, 99);
          if (sel < 85)      send_put(CHAR_W'($urandom_range(CHAR_SPACE, CHAR_DEL)));
          else if (sel < 90) send_put(CHAR_TAB);
          else if (sel < 94) send_put(CHAR_BS);
          else if (sel < 96) send_put(CHAR_CR);
          else               send_put(CHAR_W'($urandom_range(0, 255)));
        end
      end else if (pick < 62) begin
        if ($urandom_range(0, 1)) send_put(CHAR_CR);
        repeat ($urandom_range(1, 30)) send_put(CHAR_LF);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_read();
      end else if (pick < 86) begin
        send_request(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)),
                     ROW_OUT_W'($urandom_range(0, 31)), COL_OUT_W'($urandom_range(0, 127)));
      end else if (pick < 90) begin
        send_request(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                     ROW_OUT_W'($urandom_range(0, 31)), COL_OUT_W'($urandom_range(0, 127)));
      end else begin
        repeat ($urandom_range(1, 5)) send_put(CHAR_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    // Drive every input to a known value before the first edge
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type    = REQ_PUT;
    char_code   = '0;
    cell_row    = '0;
    cell_col    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_FORE_COLOR;
    cfg_wdata   = '0;
    drain_done  = 1'b0;
    holding     = 1'b0;
    idle_pct    = 0;
    n_put       = 0;
    n_read      = 0;
    n_clear     = 0;
    n_unused    = 0;
    n_cfg       = 0;
    cycle_count = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold off through the clearing pass that follows reset
    do @(posedge clk_i); while (busy);
    set_colours(FORE_RESET, BACK_RESET, 1'b0);

    // Directed: printable extremes, ignored bytes, every control byte,
    // backspace at column 0, tabs, reads on and off the screen, the spare
    // request code and a clear.
    send_put(8'h41);
    send_put(CHAR_SPACE);
    send_put(CHAR_DEL);
    send_put(8'h00);
    send_put(8'h1F);
    send_put(8'h80);
    send_put(8'hFF);
    send_put(CHAR_BS);
    send_put(CHAR_CR);
    send_put(CHAR_BS);
    send_put(CHAR_TAB);
    send_put(CHAR_TAB);
    send_put(CHAR_LF);
    send_request(REQ_READ, 8'h00, '0, '0);
    send_request(REQ_READ, 8'hFF, '0, COL_OUT_W'(2));
    send_request(REQ_READ, 8'h00, ROW_OUT_W'(ROWS-1), COL_OUT_W'(COLS-1));
    send_request(REQ_READ, 8'h00, ROW_OUT_W'(ROWS), '0);
    send_request(REQ_READ, 8'h00, '0, COL_OUT_W'(COLS));
    send_request(REQ_READ, 8'h00, 5'h1F, 7'h7F);
    send_request(REQ_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    send_request(REQ_CLEAR, 8'h00, '0, '0);
    send_request(REQ_READ, 8'h00, '0, '0);
    send_put(8'h7E);

    // Random phases, each at its own colour setting; the sender idles at 0, 51, 34 and 0 percent
    drain();
    set_colours(4'h0, 4'hF, 1'b1);
    idle_pct = 0;
    run_random(ITEMS_PER_PHASE);

    drain();
    set_colours(4'hF, 4'hF, 1'b0);
    idle_pct = 51;
    run_random(ITEMS_PER_PHASE);

    drain();
    set_colours(4'h0, 4'h0, 1'b1);
    idle_pct = 34;
    run_random(ITEMS_PER_PHASE);

    drain();
    set_colours(COLOR_W'($urandom_range(0, 15)), COLOR_W'($urandom_range(0, 15)), 1'b0);
    idle_pct = 0;
    run_random(ITEMS_PER_PHASE);

    // Wait for the last results, let the block settle, then
    // ask the checker for anything still outstanding
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("Covered %0d requests: %0d puts, %0d reads, %0d clears, %0d spare codes",
             n_put + n_read + n_clear + n_unused, n_put, n_read, n_clear, n_unused);
    $display("Colour register transfers: %0d, sender idling at 0, 34 and 51 percent",
             n_cfg);
    if (error_count == 0) begin
      $display("text_console_char_writer: match");
    end else begin
      $display("text_console_char_writer: mismatch");
    end
    $finish;
  end

endmodule
